FILE: hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared action codes, arithmetic unit control and fixed field widths.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned IMM_W    = 32;
  localparam int unsigned POP_W    = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NOP  = 3'd0,
    ACT_PUSH = 3'd1,
    ACT_ADD  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_MUL  = 3'd4,
    ACT_POP  = 3'd5,
    ACT_HALT = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

endpackage

FILE: hdl/sme_if.sv
// ----------------------------------------------------------------------------
// Stack machine executor channels
// Valid/ready channels for instructions and for their results.
// ----------------------------------------------------------------------------
interface sme_in_if;
  logic                                valid;
  logic                                ready;
  logic        [sme_pkg::ACTION_W-1:0] action;
  logic signed [sme_pkg::IMM_W-1:0]    immediate;

  modport source (output valid, output action, output immediate, input ready);
  modport sink   (input valid, input action, input immediate, output ready);
endinterface

interface sme_out_if #(
  parameter int unsigned DEPTH_W = 9
);
  logic                             valid;
  logic                             ready;
  logic signed [sme_pkg::POP_W-1:0] pop_value;
  logic                             pop_valid;
  logic                             div_error;
  logic                             stack_error;
  logic                             halted;
  logic        [DEPTH_W-1:0]        stack_depth;

  modport source (
    output valid, output pop_value, output pop_valid, output div_error,
    output stack_error, output halted, output stack_depth, input ready
  );
  modport sink (
    input valid, input pop_value, input pop_valid, input div_error,
    input stack_error, input halted, input stack_depth, output ready
  );
endinterface

FILE: hdl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one stack instruction per input transaction on a memory-held stack.
// ----------------------------------------------------------------------------
// Each instruction steps through idle, top read, next read, check, wait on the
// arithmetic unit and write as its action needs, then waits in done until the
// output register is free. A new instruction is taken only back in idle; the
// shared adder of the arithmetic unit and the single read port of the stack
// memory set this sequence.
// Reset clears depth, registers and the halt flag; the stack memory is not
// cleared, and the block is ready in the first cycle after reset.
module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  sme_in_if.sink   in_i,
  sme_out_if.source out_o
);
  import sme_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_NEXT,
    ST_CHECK,
    ST_WAIT,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e                       state_q;
  action_e                      op_q;
  logic [DEPTH_W-1:0]           depth_q;
  logic signed [WORD_WIDTH-1:0] first_q;
  logic signed [WORD_WIDTH-1:0] second_q;
  logic [WORD_WIDTH-1:0]        result_q;
  logic                         halt_q;
  logic                         pop_valid_q;
  logic                         div_err_q;
  logic                         stk_err_q;

  logic                         out_valid_q;
  logic signed [POP_W-1:0]      out_pop_value_q;
  logic                         out_pop_valid_q;
  logic                         out_div_err_q;
  logic                         out_stk_err_q;
  logic                         out_halted_q;
  logic [DEPTH_W-1:0]           out_depth_q;

  logic [WORD_WIDTH-1:0]        stack_mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0]        rdata_q;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [WORD_WIDTH-1:0]        mem_wdata;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_raddr;

  logic                         in_fire;
  logic                         out_fire;
  action_e                      act;
  logic [WORD_WIDTH-1:0]        imm_word;
  logic [DEPTH_W-1:0]           depth_m1;
  logic [DEPTH_W-1:0]           depth_m2;
  logic                         stack_full;
  logic                         div_reject;
  alu_ctrl_t                    alu_ctrl;
  logic                         alu_done;
  logic [WORD_WIDTH-1:0]        alu_result;
  logic signed [POP_W-1:0]      pop_word;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign act        = action_e'(in_i.action);
  assign imm_word   = WORD_WIDTH'(in_i.immediate);
  assign depth_m1   = depth_q - DEPTH_W'(1);
  assign depth_m2   = depth_q - DEPTH_W'(2);
  assign stack_full = (depth_q == DEPTH_W'(STACK_DEPTH));
  assign pop_word   = POP_W'(first_q);
  assign div_reject = (op_q == ACT_DIV)
                   && ((first_q > second_q) || (first_q == '0) || (second_q == '0));

  always_comb begin
    alu_ctrl.start = (state_q == ST_CHECK) && !div_reject;
    case (op_q)
      ACT_ADD: alu_ctrl.op = ALU_ADD;
      ACT_MUL: alu_ctrl.op = ALU_MUL;
      default: alu_ctrl.op = ALU_DIV;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth_q[ADDR_W-1:0];
    mem_wdata = result_q;
    if (state_q == ST_IDLE) begin
      mem_we    = in_fire && !halt_q && (act == ACT_PUSH) && !stack_full;
      mem_wdata = imm_word;
    end else if (state_q == ST_WRITE) begin
      mem_we = 1'b1;
    end
    mem_re    = (state_q == ST_IDLE) || (state_q == ST_RD_TOP);
    mem_raddr = (state_q == ST_RD_TOP) ? depth_m2[ADDR_W-1:0] : depth_m1[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= stack_mem[mem_raddr];
    end
  end

  sme_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .opa_i    (first_q),
    .opb_i    (second_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      op_q            <= ACT_NOP;
      depth_q         <= '0;
      first_q         <= '0;
      second_q        <= '0;
      result_q        <= '0;
      halt_q          <= 1'b0;
      pop_valid_q     <= 1'b0;
      div_err_q       <= 1'b0;
      stk_err_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      out_pop_value_q <= '0;
      out_pop_valid_q <= 1'b0;
      out_div_err_q   <= 1'b0;
      out_stk_err_q   <= 1'b0;
      out_halted_q    <= 1'b0;
      out_depth_q     <= '0;
    end else begin
      if (out_fire && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            pop_valid_q <= 1'b0;
            div_err_q   <= 1'b0;
            stk_err_q   <= 1'b0;
            op_q        <= act;
            state_q     <= ST_DONE;
            if (!halt_q) begin
              unique case (act) inside
                ACT_PUSH: begin
                  if (stack_full) begin
                    stk_err_q <= 1'b1;
                  end else begin
                    depth_q <= depth_q + DEPTH_W'(1);
                  end
                end
                ACT_ADD, ACT_DIV, ACT_MUL: begin
                  if (depth_q < DEPTH_W'(2)) begin
                    stk_err_q <= 1'b1;
                  end else begin
                    state_q <= ST_RD_TOP;
                  end
                end
                ACT_POP: begin
                  if (depth_q == '0) begin
                    stk_err_q <= 1'b1;
                  end else begin
                    state_q <= ST_RD_TOP;
                  end
                end
                ACT_HALT: halt_q <= 1'b1;
                default: begin
                end
              endcase
            end
          end
        end
        ST_RD_TOP: begin
          first_q <= rdata_q;
          if (op_q == ACT_POP) begin
            depth_q     <= depth_m1;
            pop_valid_q <= 1'b1;
            state_q     <= ST_DONE;
          end else begin
            state_q <= ST_RD_NEXT;
          end
        end
        ST_RD_NEXT: begin
          second_q <= rdata_q;
          depth_q  <= depth_m2;
          state_q  <= ST_CHECK;
        end
        ST_CHECK: begin
          if (div_reject) begin
            div_err_q <= 1'b1;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (alu_done) begin
            result_q <= alu_result;
            state_q  <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          depth_q <= depth_q + DEPTH_W'(1);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q     <= 1'b1;
            out_pop_value_q <= pop_valid_q ? pop_word : '0;
            out_pop_valid_q <= pop_valid_q;
            out_div_err_q   <= div_err_q;
            out_stk_err_q   <= stk_err_q;
            out_halted_q    <= halt_q;
            out_depth_q     <= depth_q;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pop_value   = out_pop_value_q;
  assign out_o.pop_valid   = out_pop_valid_q;
  assign out_o.div_error   = out_div_err_q;
  assign out_o.stack_error = out_stk_err_q;
  assign out_o.halted      = out_halted_q;
  assign out_o.stack_depth = out_depth_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("Stack depth exceeds the stack size.");

  a_halted_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && halt_q |=> (state_q == ST_DONE) && $stable(depth_q))
    else $error("An item after halt changed the stack.");

  a_alu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == ST_WAIT))
    else $error("Arithmetic result arrived outside the wait state.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_pop_valid_q && (out_stk_err_q || out_div_err_q)))
    else $error("A successful pop also reports an error.");

  a_result_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |=> depth_q == $past(depth_q) + DEPTH_W'(1))
    else $error("Arithmetic result was not pushed.");

endmodule

FILE: hdl/sme_alu.sv
// ----------------------------------------------------------------------------
// Stack machine arithmetic unit
// One shared adder serves add, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module sme_alu #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sme_pkg::alu_ctrl_t    ctrl_i,
  input  logic [WORD_WIDTH-1:0] opa_i,
  input  logic [WORD_WIDTH-1:0] opb_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] result_o
);
  import sme_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEG_D,
    S_NEG_N,
    S_MUL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [WORD_WIDTH-1:0] acc_q;
  logic [WORD_WIDTH-1:0] aux_q;
  logic [WORD_WIDTH-1:0] sh_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  neg_q;

  logic [WORD_WIDTH:0]   add_x;
  logic [WORD_WIDTH:0]   add_y;
  logic                  add_sub;
  logic [WORD_WIDTH+1:0] add_sum;
  logic                  div_ge;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        add_x = {1'b0, opa_i};
        add_y = {1'b0, opb_i};
      end
      S_NEG_D: begin
        add_y   = {1'b0, aux_q};
        add_sub = aux_q[WORD_WIDTH-1];
      end
      S_NEG_N: begin
        add_y   = {1'b0, sh_q};
        add_sub = sh_q[WORD_WIDTH-1];
      end
      S_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, aux_q};
      end
      S_DIV: begin
        add_x   = {acc_q, sh_q[WORD_WIDTH-1]};
        add_y   = {1'b0, aux_q};
        add_sub = 1'b1;
      end
      S_FIX: begin
        add_y   = {1'b0, sh_q};
        add_sub = neg_q;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + (WORD_WIDTH + 2)'(add_sub);
  assign div_ge  = add_sum[WORD_WIDTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      aux_q   <= '0;
      sh_q    <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ctrl_i.start) begin
            unique case (ctrl_i.op)
              ALU_ADD: begin
                acc_q   <= add_sum[WORD_WIDTH-1:0];
                state_q <= S_DONE;
              end
              ALU_MUL: begin
                acc_q   <= '0;
                aux_q   <= opb_i;
                sh_q    <= opa_i;
                cnt_q   <= CNT_W'(WORD_WIDTH);
                state_q <= S_MUL;
              end
              ALU_DIV: begin
                acc_q   <= '0;
                aux_q   <= opa_i;
                sh_q    <= opb_i;
                neg_q   <= opa_i[WORD_WIDTH-1] ^ opb_i[WORD_WIDTH-1];
                state_q <= S_NEG_D;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_NEG_D: begin
          aux_q   <= add_sum[WORD_WIDTH-1:0];
          state_q <= S_NEG_N;
        end
        S_NEG_N: begin
          sh_q    <= add_sum[WORD_WIDTH-1:0];
          cnt_q   <= CNT_W'(WORD_WIDTH);
          state_q <= S_DIV;
        end
        S_MUL: begin
          if (sh_q[0]) begin
            acc_q <= add_sum[WORD_WIDTH-1:0];
          end
          aux_q <= aux_q << 1;
          sh_q  <= sh_q >> 1;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            acc_q <= add_sum[WORD_WIDTH-1:0];
          end else begin
            acc_q <= {acc_q[WORD_WIDTH-2:0], sh_q[WORD_WIDTH-1]};
          end
          sh_q  <= {sh_q[WORD_WIDTH-2:0], div_ge};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          acc_q   <= add_sum[WORD_WIDTH-1:0];
          state_q <= S_DONE;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = (state_q == S_DONE);
  assign result_o = acc_q;

endmodule

FILE: sim/stack_machine_executor_checker.sv
// ----------------------------------------------------------------------------
// Stack machine executor checker
// Watches the instruction and result channels, predicts the result of every
// accepted instruction and compares each result transaction against it.
// ----------------------------------------------------------------------------
module stack_machine_executor_checker #(
  parameter int unsigned STACK_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sme_in_if           in_mon,
  sme_out_if          out_mon,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic               pop_valid;
    logic               div_error;
    logic               stack_error;
    logic               halted;
    logic [8:0]         stack_depth;
  } status_t;

  logic [31:0] stack_words [STACK_WORDS];
  int unsigned depth;
  logic        halt_seen;
  status_t     due_results [$];
  int unsigned reported;

  function automatic status_t execute_instr(input logic [2:0] act, input logic [31:0] imm);
    status_t            res;
    logic signed [31:0] top;
    logic signed [31:0] nxt;
    longint             quo;
    res = '0;
    if (!halt_seen) begin
      case (act)
        ACT_PUSH: begin
          if (depth == STACK_WORDS) begin
            res.stack_error = 1'b1;
          end else begin
            stack_words[depth] = imm;
            depth++;
          end
        end
        ACT_ADD, ACT_MUL, ACT_DIV: begin
          if (depth < 2) begin
            res.stack_error = 1'b1;
          end else begin
            top = stack_words[depth-1];
            nxt = stack_words[depth-2];
            depth -= 2;
            if (act == ACT_DIV) begin
              if (top > nxt || top == 0 || nxt == 0) begin
                res.div_error = 1'b1;
              end else begin
                quo = longint'(nxt) / longint'(top);
                stack_words[depth] = 32'(quo);
                depth++;
              end
            end else if (act == ACT_ADD) begin
              stack_words[depth] = top + nxt;
              depth++;
            end else begin
              stack_words[depth] = top * nxt;
              depth++;
            end
          end
        end
        ACT_POP: begin
          if (depth == 0) begin
            res.stack_error = 1'b1;
          end else begin
            depth--;
            res.pop_value = stack_words[depth];
            res.pop_valid = 1'b1;
          end
        end
        ACT_HALT: begin
          halt_seen = 1'b1;
        end
        default: begin
        end
      endcase
    end
    res.halted      = halt_seen;
    res.stack_depth = depth[8:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t got;
    status_t want;
    if (!rst_ni) begin
      depth     = 0;
      halt_seen = 1'b0;
      due_results.delete();
      reported  = 0;
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        due_results.push_back(execute_instr(in_mon.action, in_mon.immediate));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{pop_value: out_mon.pop_value, pop_valid: out_mon.pop_valid,
                div_error: out_mon.div_error, stack_error: out_mon.stack_error,
                halted: out_mon.halted, stack_depth: out_mon.stack_depth};
        if (due_results.size() == 0) begin
          errors_o++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result transaction with none expected: pop %0d/%0b div %0b stk %0b",
                     $realtime, got.pop_value, got.pop_valid, got.div_error, got.stack_error);
          end
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors_o++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch, expected pop %0d/%0b div %0b stk %0b halt %0b depth %0d",
                       $realtime, want.pop_value, want.pop_valid, want.div_error,
                       want.stack_error, want.halted, want.stack_depth);
              $display("%0t:           actual   pop %0d/%0b div %0b stk %0b halt %0b depth %0d",
                       $realtime, got.pop_value, got.pop_valid, got.div_error,
                       got.stack_error, got.halted, got.stack_depth);
            end
          end
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

FILE: sim/stack_machine_executor_tb.sv
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Drives directed and random instruction streams with random idle cycles on
// both channels, lets the checker predict and compare, and gives the verdict.
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  localparam int unsigned STACK_WORDS = 256;
  localparam int unsigned IDLE_LIMIT  = 5000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned errors;
  int unsigned pending;
  int unsigned sent;
  int unsigned idle_cycles = 0;
  logic        steady;
  logic        long_hold;

  sme_in_if                 in_ch ();
  sme_out_if #(.DEPTH_W(9)) out_ch ();

  always #1 clk_i = ~clk_i;

  stack_machine_executor #(
    .STACK_DEPTH(STACK_WORDS),
    .WORD_WIDTH (32)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  stack_machine_executor_checker #(
    .STACK_WORDS(STACK_WORDS)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return 32'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_arith();
    case ($urandom_range(0, 2))
      0: return ACT_ADD;
      1: return ACT_MUL;
      default: return ACT_DIV;
    endcase
  endfunction

  task automatic send_instr(input logic [2:0] act, input logic [31:0] imm);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.immediate <= imm;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed operand/operator sequences, with some loose noise.
  task automatic run_mixed(input int unsigned upto);
    int unsigned roll;
    logic [2:0]  act;
    while (sent < upto) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_instr(ACT_PUSH, rand_word());
        send_instr(ACT_PUSH, rand_word());
        send_instr(rand_arith(), $urandom);
      end else if (roll < 65) begin
        send_instr(ACT_PUSH, rand_word());
        send_instr(ACT_POP, $urandom);
      end else if (roll < 75) begin
        send_instr(ACT_PUSH, rand_word());
      end else if (roll < 85) begin
        send_instr(ACT_POP, $urandom);
      end else if (roll < 95) begin
        act = 3'($urandom_range(0, 6));
        if (act == ACT_HALT) begin
          act = 3'd7;
        end
        send_instr(act, $urandom);
      end else begin
        send_instr(rand_arith(), $urandom);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("stack_machine_executor_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    logic        held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_NOP;
    in_ch.immediate = '0;
    sent            = 0;
    steady          = 1'b0;
    long_hold       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Underflows on an empty stack, then the word extremes through every arithmetic operation.
    send_instr(ACT_POP, 32'h0);
    send_instr(ACT_ADD, 32'h0);
    send_instr(ACT_PUSH, 32'h7FFF_FFFF);
    send_instr(ACT_DIV, 32'hFFFF_FFFF);
    send_instr(ACT_PUSH, 32'h8000_0000);
    send_instr(ACT_ADD, 32'h0);
    send_instr(ACT_PUSH, 32'h8000_0000);
    send_instr(ACT_MUL, 32'h0);
    send_instr(ACT_PUSH, 32'hFFFF_FFFF);
    send_instr(ACT_DIV, 32'h0);
    send_instr(ACT_PUSH, 32'd100);
    send_instr(ACT_PUSH, 32'd7);
    send_instr(ACT_DIV, 32'h0);
    send_instr(ACT_PUSH, 32'hFFFF_FFF9);
    send_instr(ACT_DIV, 32'h0);
    send_instr(ACT_PUSH, 32'h0);
    send_instr(ACT_DIV, 32'h0);
    send_instr(ACT_PUSH, 32'h0);
    send_instr(ACT_PUSH, 32'd5);
    send_instr(ACT_DIV, 32'h0);
    send_instr(ACT_NOP, 32'hFFFF_FFFF);
    send_instr(3'd7, 32'hFFFF_FFFF);
    send_instr(ACT_PUSH, 32'h1234_5678);
    send_instr(ACT_POP, 32'hFFFF_FFFF);
    send_instr(ACT_POP, 32'h0);

    run_mixed(150);
    long_hold = 1'b1;
    run_mixed(300);
    steady = 1'b1;
    run_mixed(400);
    steady = 1'b0;
    wait_for_results();
    run_mixed(550);

    // Empty the stack, fill it past the top and work on it while full.
    repeat (STACK_WORDS + 4) send_instr(ACT_POP, $urandom);
    repeat (STACK_WORDS + 4) send_instr(ACT_PUSH, rand_word());
    send_instr(ACT_ADD, $urandom);
    send_instr(ACT_PUSH, rand_word());
    send_instr(ACT_PUSH, rand_word());
    send_instr(ACT_MUL, $urandom);
    send_instr(ACT_DIV, $urandom);
    send_instr(ACT_POP, $urandom);

    run_mixed(1220);
    wait_for_results();

    // After a halt every instruction is ignored.
    send_instr(ACT_HALT, $urandom);
    for (int a = 0; a < 8; a++) begin
      send_instr(3'(a), $urandom);
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("stack_machine_executor_tb: done, clean");
    end else begin
      $display("stack_machine_executor_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sme_pkg.sv
hdl/sme_if.sv
hdl/sme_alu.sv
hdl/stack_machine_executor.sv
sim/stack_machine_executor_checker.sv
sim/stack_machine_executor_tb.sv
